[hw/rtl/tlr_pkg.sv]
// ----------------------------------------------------------------------------
// tlr_pkg: shared types and constants of the tensor layout reorder core
// Register indexes, layout mode codes, the decoded configuration bundle and
// the per-item position record passed from the walker to the address pipe.
// ----------------------------------------------------------------------------
package tlr_pkg;

  // parameter defaults
  localparam int ADDR_BITS_DEF = 24;
  localparam int DATA_BITS_DEF = 32;
  localparam int MAX_BLOCK_DEF = 16;

  // full-precision destination index width (largest index stays below 2**47)
  localparam int FULL_BITS = 48;

  // configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 13;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_LAYOUT_MODE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_SHIFT   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BATCH_COUNT   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT  = 3'd5;

  // layout modes; the unused code behaves as nchw to nhwc
  localparam logic [1:0] MODE_TO_NHWC  = 2'd0;
  localparam logic [1:0] MODE_TO_BLOCK = 2'd1;
  localparam logic [1:0] MODE_UNBLOCK  = 2'd2;

  // decoded configuration: counts clamped, block size resolved
  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  shift;
    logic [4:0]  bs;
    logic [8:0]  nn;
    logic [12:0] cc;
    logic [12:0] hh;
    logic [12:0] ww;
    logic [9:0]  nblk;
  } cfg_t;

  // position of one item in the source tensor
  typedef struct packed {
    logic        real_elem;
    logic        last;
    logic [7:0]  n;
    logic [16:0] c;
    logic [11:0] h;
    logic [11:0] w;
  } walk_t;

endpackage

[hw/rtl/tlr_cfg.sv]
// ----------------------------------------------------------------------------
// tlr_cfg: configuration registers
// Holds the six writable registers and decodes them into clamped counts,
// the effective channel block size and the channel block count.
// ----------------------------------------------------------------------------
module tlr_cfg #(
  parameter int MAX_BLOCK = tlr_pkg::MAX_BLOCK_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [tlr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tlr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output tlr_pkg::cfg_t                       cfg
);

  logic [1:0]  layout_mode;
  logic [2:0]  block_shift;
  logic [8:0]  batch_count;
  logic [12:0] channel_count;
  logic [12:0] row_count;
  logic [12:0] column_count;

  logic [2:0]  shift_sel;
  logic [13:0] blk_sum;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      layout_mode   <= tlr_pkg::MODE_TO_NHWC;
      block_shift   <= 3'd4;
      batch_count   <= 9'd1;
      channel_count <= 13'd16;
      row_count     <= 13'd1;
      column_count  <= 13'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tlr_pkg::REG_LAYOUT_MODE:   layout_mode   <= cfg_data[1:0];
        tlr_pkg::REG_BLOCK_SHIFT:   block_shift   <= cfg_data[2:0];
        tlr_pkg::REG_BATCH_COUNT:   batch_count   <= cfg_data[8:0];
        tlr_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data;
        tlr_pkg::REG_ROW_COUNT:     row_count     <= cfg_data;
        tlr_pkg::REG_COLUMN_COUNT:  column_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  // decode: zero counts read as one, large counts saturate
  always_comb begin
    cfg.mode = layout_mode;
    cfg.nn = (batch_count == 9'd0) ? 9'd1 :
             (batch_count > 9'd256) ? 9'd256 : batch_count;
    cfg.cc = (channel_count == 13'd0) ? 13'd1 :
             (channel_count > 13'd4096) ? 13'd4096 : channel_count;
    cfg.hh = (row_count == 13'd0) ? 13'd1 :
             (row_count > 13'd4096) ? 13'd4096 : row_count;
    cfg.ww = (column_count == 13'd0) ? 13'd1 :
             (column_count > 13'd4096) ? 13'd4096 : column_count;

    // block size 8 or 16, capped by the largest supported block
    shift_sel = (block_shift == 3'd3) ? 3'd3 : 3'd4;
    cfg.shift = shift_sel;
    cfg.bs    = 5'd1 << shift_sel;
    if (cfg.bs > 5'(MAX_BLOCK)) begin
      cfg.bs    = 5'(MAX_BLOCK);
      cfg.shift = (MAX_BLOCK >= 16) ? 3'd4 : 3'd3;
    end

    // channel blocks, rounded up
    blk_sum  = 14'(cfg.cc) + 14'(cfg.bs) - 14'd1;
    cfg.nblk = 10'(blk_sum >> cfg.shift);
  end

endmodule

[hw/rtl/tlr_walk.sv]
// ----------------------------------------------------------------------------
// tlr_walk: source position counters
// Tracks batch, channel (or channel block), row, column and lane of the
// current item, flags padding lanes and the final element, and advances
// on every accepted item.
// ----------------------------------------------------------------------------
module tlr_walk (
  input  logic           clk,
  input  logic           rst,
  input  tlr_pkg::cfg_t  cfg,
  input  logic           step,
  output tlr_pkg::walk_t pos
);

  logic [7:0]  batch_pos;
  logic [11:0] chan_pos;
  logic [11:0] row_pos;
  logic [11:0] col_pos;
  logic [3:0]  lane_pos;

  logic [7:0]  batch_pos_next;
  logic [11:0] chan_pos_next;
  logic [11:0] row_pos_next;
  logic [11:0] col_pos_next;
  logic [3:0]  lane_pos_next;

  logic        unblock;
  logic [12:0] chan_cnt;
  logic [4:0]  lane_inc;
  logic [12:0] col_inc;
  logic [12:0] row_inc;
  logic [12:0] chan_inc;
  logic [8:0]  batch_inc;
  logic        lane_wrap;
  logic        col_step;
  logic        col_wrap;
  logic        row_wrap;
  logic        chan_wrap;
  logic [17:0] c_inc;
  logic        last_common;

  assign unblock  = (cfg.mode == tlr_pkg::MODE_UNBLOCK);
  assign chan_cnt = unblock ? 13'(cfg.nblk) : cfg.cc;

  // increments and wrap detection
  always_comb begin
    lane_inc  = 5'(lane_pos) + 5'd1;
    col_inc   = 13'(col_pos) + 13'd1;
    row_inc   = 13'(row_pos) + 13'd1;
    chan_inc  = 13'(chan_pos) + 13'd1;
    batch_inc = 9'(batch_pos) + 9'd1;
    lane_wrap = (lane_inc >= cfg.bs);
    col_step  = unblock ? lane_wrap : 1'b1;
    col_wrap  = (col_inc >= cfg.ww);
    row_wrap  = (row_inc >= cfg.hh);
    chan_wrap = (chan_inc >= chan_cnt);
  end

  // carry chain: lane (unblocking only), column, row, channel, batch
  always_comb begin
    lane_pos_next  = lane_pos;
    col_pos_next   = col_pos;
    row_pos_next   = row_pos;
    chan_pos_next  = chan_pos;
    batch_pos_next = batch_pos;
    if (unblock) begin
      lane_pos_next = lane_wrap ? 4'd0 : lane_inc[3:0];
    end
    if (col_step) begin
      col_pos_next = col_wrap ? 12'd0 : col_inc[11:0];
      if (col_wrap) begin
        row_pos_next = row_wrap ? 12'd0 : row_inc[11:0];
        if (row_wrap) begin
          chan_pos_next = chan_wrap ? 12'd0 : chan_inc[11:0];
          if (chan_wrap) begin
            batch_pos_next = (batch_inc >= cfg.nn) ? 8'd0 : batch_inc[7:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_pos <= '0;
      chan_pos  <= '0;
      row_pos   <= '0;
      col_pos   <= '0;
      lane_pos  <= '0;
    end else if (step) begin
      batch_pos <= batch_pos_next;
      chan_pos  <= chan_pos_next;
      row_pos   <= row_pos_next;
      col_pos   <= col_pos_next;
      lane_pos  <= lane_pos_next;
    end
  end

  // channel index, padding and last-element flags
  always_comb begin
    pos.n = batch_pos;
    pos.h = row_pos;
    pos.w = col_pos;
    pos.c = unblock ? (17'(chan_pos) * 17'(cfg.bs) + 17'(lane_pos)) : 17'(chan_pos);
    c_inc = 18'(pos.c) + 18'd1;
    last_common = (batch_inc == cfg.nn) && (row_inc == cfg.hh) && (col_inc == cfg.ww);
    if (unblock) begin
      pos.real_elem = (pos.c < 17'(cfg.cc));
      pos.last      = last_common && (chan_inc == 13'(cfg.nblk)) &&
                      (c_inc == 18'(cfg.cc));
    end else begin
      pos.real_elem = 1'b1;
      pos.last      = last_common && (chan_inc == cfg.cc);
    end
  end

endmodule

[hw/rtl/tlr_addr.sv]
// ----------------------------------------------------------------------------
// tlr_addr: destination address pipeline
// Five register stages: item capture, three multiply-add steps of the
// mixed-radix index, and a final block scale with overflow check feeding
// the result register. Stages advance independently so bubbles collapse.
// ----------------------------------------------------------------------------
module tlr_addr #(
  parameter int ADDR_BITS = tlr_pkg::ADDR_BITS_DEF,
  parameter int DATA_BITS = tlr_pkg::DATA_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tlr_pkg::cfg_t        cfg,
  input  logic                 load,
  input  tlr_pkg::walk_t       pos,
  input  logic [DATA_BITS-1:0] value_in,
  output logic                 take_ready,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [ADDR_BITS-1:0] dest_address,
  output logic [DATA_BITS-1:0] moved_value,
  output logic                 last_element,
  output logic                 address_overflow
);

  localparam int FB = tlr_pkg::FULL_BITS;

  logic                 v0, v1, v2, v3;
  logic                 r0, r1, r2, r3, r4;
  tlr_pkg::walk_t       w0, w1, w2, w3;
  logic [DATA_BITS-1:0] d0, d1, d2, d3;
  logic [20:0]          p1;
  logic [33:0]          p2;
  logic [FB-1:0]        p3;

  logic                 mode_blk;
  logic                 mode_unblk;
  logic                 mode_nhwc;

  logic [12:0]          m1;
  logic [16:0]          a1;
  logic [20:0]          p1_next;
  logic [12:0]          m2;
  logic [11:0]          a2;
  logic [33:0]          p2_next;
  logic [12:0]          m3;
  logic [16:0]          a3;
  logic [FB-1:0]        p3_next;
  logic [3:0]           lane;
  logic [FB-1:0]        full_next;

  assign mode_blk   = (cfg.mode == tlr_pkg::MODE_TO_BLOCK);
  assign mode_unblk = (cfg.mode == tlr_pkg::MODE_UNBLOCK);
  assign mode_nhwc  = !mode_blk && !mode_unblk;

  // stage readiness, from the result register backward
  assign r4 = !result_valid || !result_stall;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign r0 = !v0 || r1;
  assign take_ready = r0;

  // first multiply-add: batch by outer count
  always_comb begin
    if (mode_unblk) begin
      m1 = cfg.cc;
      a1 = w0.c;
    end else if (mode_blk) begin
      m1 = 13'(cfg.nblk);
      a1 = w0.c >> cfg.shift;
    end else begin
      m1 = cfg.hh;
      a1 = 17'(w0.h);
    end
    p1_next = 21'(w0.n) * 21'(m1) + 21'(a1);
  end

  // second multiply-add
  always_comb begin
    m2 = mode_nhwc ? cfg.ww : cfg.hh;
    a2 = mode_nhwc ? w1.w : w1.h;
    p2_next = 34'(p1) * 34'(m2) + 34'(a2);
  end

  // third multiply-add
  always_comb begin
    m3 = mode_nhwc ? cfg.cc : cfg.ww;
    a3 = mode_nhwc ? w2.c : 17'(w2.w);
    p3_next = FB'(p2) * FB'(m3) + FB'(a3);
  end

  // block scale and lane for the blocked layout; block size is a power of two
  always_comb begin
    lane = w3.c[3:0] & 4'(cfg.bs - 5'd1);
    full_next = mode_blk ? ((p3 << cfg.shift) + FB'(lane)) : p3;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (r0) v0 <= load && pos.real_elem;
      if (r1) v1 <= v0;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) result_valid <= v3;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (r0) begin
      w0 <= pos;
      d0 <= value_in;
    end
    if (r1) begin
      w1 <= w0;
      d1 <= d0;
      p1 <= p1_next;
    end
    if (r2) begin
      w2 <= w1;
      d2 <= d1;
      p2 <= p2_next;
    end
    if (r3) begin
      w3 <= w2;
      d3 <= d2;
      p3 <= p3_next;
    end
    if (r4) begin
      dest_address     <= full_next[ADDR_BITS-1:0];
      address_overflow <= |(full_next >> ADDR_BITS);
      moved_value      <= d3;
      last_element     <= w3.last;
    end
  end

endmodule

[hw/rtl/tensor_layout_reorder_core.sv]
// ----------------------------------------------------------------------------
// tensor_layout_reorder_core: streaming tensor layout converter
// an accepted item passes the capture, multiply-add and output registers;
// throughput is one item per cycle while result_stall is low, set by the
// address pipe (three registered multiply-add steps and a block scale step)
// padding lanes in unblocking mode are consumed without a result
// rst (synchronous) restores register defaults and zeroes all counters
// ----------------------------------------------------------------------------
module tensor_layout_reorder_core #(
  parameter int ADDR_BITS = tlr_pkg::ADDR_BITS_DEF,
  parameter int DATA_BITS = tlr_pkg::DATA_BITS_DEF,
  parameter int MAX_BLOCK = tlr_pkg::MAX_BLOCK_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [tlr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tlr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic [DATA_BITS-1:0]               element_value,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [ADDR_BITS-1:0]               dest_address,
  output logic [DATA_BITS-1:0]               moved_value,
  output logic                               last_element,
  output logic                               address_overflow
);

  tlr_pkg::cfg_t  cfg;
  tlr_pkg::walk_t pos;
  logic           take_ready;
  logic           accept;

  // item handshake
  assign item_stall = !take_ready;
  assign accept     = item_valid && take_ready;

  tlr_cfg #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tlr_walk u_walk (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (accept),
    .pos  (pos)
  );

  tlr_addr #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_addr (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .load             (accept),
    .pos              (pos),
    .value_in         (element_value),
    .take_ready       (take_ready),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .dest_address     (dest_address),
    .moved_value      (moved_value),
    .last_element     (last_element),
    .address_overflow (address_overflow)
  );

endmodule
